### src/svmm_pkg.sv
// shared constants, types and helper functions of the svpwm min-max injection block
// no dependencies
`default_nettype none

package svmm_pkg;

  localparam int CMD_WIDTH    = 16;
  localparam int COUNT_WIDTH  = 16;
  localparam int GUARD_WIDTH  = 12;
  localparam int FRAC_BITS    = CMD_WIDTH - 2;
  localparam int SCALE_BITS   = 16;
  localparam int SCALE_WIDTH  = SCALE_BITS + 1;
  localparam int LIMIT_WIDTH  = FRAC_BITS + 2;
  localparam int SPAN_WIDTH   = CMD_WIDTH;
  localparam int SUM_WIDTH    = CMD_WIDTH + 1;
  localparam int W_WIDTH      = FRAC_BITS + 3;
  localparam int SECTOR_WIDTH = 3;
  localparam int ADDR_WIDTH   = 4;
  localparam int DATA_WIDTH   = 32;

  localparam logic [SCALE_WIDTH-1:0] SCALE_ONE = SCALE_WIDTH'(2 ** SCALE_BITS);

  localparam logic [SECTOR_WIDTH-1:0] SECTOR_ABC = 3'd1;
  localparam logic [SECTOR_WIDTH-1:0] SECTOR_BAC = 3'd2;
  localparam logic [SECTOR_WIDTH-1:0] SECTOR_BCA = 3'd3;
  localparam logic [SECTOR_WIDTH-1:0] SECTOR_CBA = 3'd4;
  localparam logic [SECTOR_WIDTH-1:0] SECTOR_CAB = 3'd5;
  localparam logic [SECTOR_WIDTH-1:0] SECTOR_ACB = 3'd6;

  localparam int S_IN     = 0;
  localparam int S_SPAN   = 1;
  localparam int S_DIV    = 2;
  localparam int S_MUL    = S_DIV + SCALE_BITS;
  localparam int S_RND    = S_MUL + 1;
  localparam int S_MRG    = S_RND + 1;
  localparam int S_W      = S_MRG + 1;
  localparam int S_PM     = S_W + 1;
  localparam int S_OUT    = S_PM + 1;
  localparam int N_STAGES = S_OUT + 1;

  typedef enum logic [ADDR_WIDTH-3:0] {
    REG_PERIOD = 2'd0,
    REG_GUARD  = 2'd1,
    REG_ENABLE = 2'd2
  } reg_idx_t;

  typedef logic signed [CMD_WIDTH-1:0] cmd_t;
  typedef logic [N_STAGES-1:0] stage_en_t;

  typedef struct packed {
    cmd_t [2:0] ph;
    logic       need;
  } div_tag_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] period;
    logic [GUARD_WIDTH-1:0] guard;
    logic                   bad;
  } timing_t;

  function automatic cmd_t max3(cmd_t a, cmd_t b, cmd_t c);
    cmd_t m;
    m = (b > a) ? b : a;
    return (c > m) ? c : m;
  endfunction

  function automatic cmd_t min3(cmd_t a, cmd_t b, cmd_t c);
    cmd_t m;
    m = (b < a) ? b : a;
    return (c < m) ? c : m;
  endfunction

endpackage

`default_nettype wire

### src/svpwm_min_max_injection.sv
// top level of the svpwm min-max injection block: register port, span stage, lanes, merge
// depends on svmm_pkg, svmm_limit_div, svmm_scale_div, svmm_lane, svmm_merge
`default_nettype none

// Takes one request of three phase commands per clock, while in_stall is low, and returns
// compare values, sector, scale factor and zero-sequence value; the scale divider is
// pipelined one quotient bit per stage, so a new request can enter every cycle unless the
// input is stalled. After a write to the period or guard register the input is stalled
// while the span limit is recomputed by a 16-step iterative divider. While enable is low
// requests are taken and dropped without a result.
module svpwm_min_max_injection (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [svmm_pkg::ADDR_WIDTH-1:0]    paddr,
  input  logic [svmm_pkg::DATA_WIDTH-1:0]    pwdata,
  output logic [svmm_pkg::DATA_WIDTH-1:0]    prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  svmm_pkg::cmd_t                   cmd_a,
  input  svmm_pkg::cmd_t                   cmd_b,
  input  svmm_pkg::cmd_t                   cmd_c,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [svmm_pkg::COUNT_WIDTH-1:0]   cmp_a,
  output logic [svmm_pkg::COUNT_WIDTH-1:0]   cmp_b,
  output logic [svmm_pkg::COUNT_WIDTH-1:0]   cmp_c,
  output logic [svmm_pkg::SECTOR_WIDTH-1:0]  sector,
  output logic [svmm_pkg::SCALE_WIDTH-1:0]   scale_factor,
  output svmm_pkg::cmd_t                   zero_seq
);
  import svmm_pkg::*;

  logic [COUNT_WIDTH-1:0] period;
  logic [GUARD_WIDTH-1:0] guard;
  logic                   enable;
  logic                   wr;
  reg_idx_t               idx;
  logic                   start;
  logic                   div_busy;
  logic                   busy;
  logic [LIMIT_WIDTH-1:0] limit;
  timing_t                tm;

  logic [N_STAGES-1:0]    v;
  stage_en_t              en;
  logic                   take;

  cmd_t [2:0]             ph0;
  cmd_t                   mx0;
  cmd_t                   mn0;
  logic [CMD_WIDTH:0]     diff0;
  div_tag_t               tag1;
  logic [SPAN_WIDTH-1:0]  span1;
  logic [SCALE_BITS-1:0]  q;
  div_tag_t               tag_q;
  logic [SCALE_WIDTH-1:0] scale_eff;
  cmd_t [2:0]             scaled;
  logic signed [SUM_WIDTH-1:0] sum;
  logic [COUNT_WIDTH-1:0] cmp [3];

  // register port
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[ADDR_WIDTH-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= '0;
      guard  <= GUARD_WIDTH'(8);
      enable <= 1'b0;
      start  <= 1'b0;
    end else begin
      start <= wr && ((idx == REG_PERIOD) || (idx == REG_GUARD));
      if (wr) begin
        case (idx)
          REG_PERIOD: period <= pwdata[COUNT_WIDTH-1:0];
          REG_GUARD:  guard  <= pwdata[GUARD_WIDTH-1:0];
          REG_ENABLE: enable <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_PERIOD: prdata = DATA_WIDTH'(period);
      REG_GUARD:  prdata = DATA_WIDTH'(guard);
      REG_ENABLE: prdata = DATA_WIDTH'(enable);
      default:    prdata = '0;
    endcase
  end

  assign tm.period = period;
  assign tm.guard  = guard;
  assign tm.bad    = ({1'b0, period} <= (COUNT_WIDTH + 1)'({guard, 1'b0}));

  svmm_limit_div u_limit (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .period (period),
    .guard  (guard),
    .busy   (div_busy),
    .limit  (limit)
  );

  assign busy = start || div_busy;

  // stage flow, each stage moves on when it is empty or the next one moves
  always_comb begin
    en[N_STAGES-1] = !v[N_STAGES-1] || !out_stall;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_stall  = busy || !en[S_IN];
  assign take      = in_valid && !in_stall && enable;
  assign out_valid = v[N_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[S_IN]) v[S_IN] <= take;
      for (int k = 1; k < N_STAGES; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // input and span stages
  assign mx0   = max3(ph0[0], ph0[1], ph0[2]);
  assign mn0   = min3(ph0[0], ph0[1], ph0[2]);
  assign diff0 = (CMD_WIDTH + 1)'($signed((CMD_WIDTH + 1)'(mx0))
               - $signed((CMD_WIDTH + 1)'(mn0)));

  always_ff @(posedge clk) begin
    if (en[S_IN]) begin
      ph0[0] <= cmd_a;
      ph0[1] <= cmd_b;
      ph0[2] <= cmd_c;
    end
    if (en[S_SPAN]) begin
      tag1.ph   <= ph0;
      tag1.need <= !tm.bad && (diff0[SPAN_WIDTH-1:0] > SPAN_WIDTH'(limit));
      span1     <= diff0[SPAN_WIDTH-1:0];
    end
  end

  svmm_scale_div u_div (
    .clk     (clk),
    .en      (en),
    .in_rem  ((SPAN_WIDTH + 1)'(limit)),
    .in_span (span1),
    .in_tag  (tag1),
    .out_q   (q),
    .out_tag (tag_q)
  );

  assign scale_eff = tag_q.need ? {1'b0, q} : SCALE_ONE;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    svmm_lane u_lane (
      .clk     (clk),
      .en      (en),
      .tm      (tm),
      .ph      (tag_q.ph[i]),
      .scale   (scale_eff),
      .sum     (sum),
      .scaled  (scaled[i]),
      .compare (cmp[i])
    );
  end

  svmm_merge u_merge (
    .clk          (clk),
    .en           (en),
    .tm           (tm),
    .scaled       (scaled),
    .scale_in     (scale_eff),
    .sum          (sum),
    .sector       (sector),
    .scale_factor (scale_factor),
    .zero_seq     (zero_seq)
  );

  assign cmp_a = cmp[0];
  assign cmp_b = cmp[1];
  assign cmp_c = cmp[2];

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst) busy |-> in_stall)
    else $error("request taken while span limit is being computed");

  a_guard_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tm.bad |-> (cmp_a >= COUNT_WIDTH'(guard))
      && (cmp_a <= period - COUNT_WIDTH'(guard)))
    else $error("compare outside guard band");

  a_sector_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sector >= SECTOR_ABC) && (sector <= SECTOR_ACB))
    else $error("sector code out of range");

  a_no_scale_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && tm.bad |-> (scale_factor == SCALE_ONE) && (zero_seq == '0))
    else $error("scaling or injection with a bad period");
`endif

endmodule

`default_nettype wire

### src/svmm_limit_div.sv
// iterative divider for the guarded span limit floor(2*one*(p-2g)/p)
// depends on svmm_pkg
`default_nettype none

module svmm_limit_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [svmm_pkg::COUNT_WIDTH-1:0] period,
  input  logic [svmm_pkg::GUARD_WIDTH-1:0] guard,
  output logic                           busy,
  output logic [svmm_pkg::LIMIT_WIDTH-1:0] limit
);
  import svmm_pkg::*;

  localparam int CNT_W = $clog2(LIMIT_WIDTH + 1);

  logic [COUNT_WIDTH:0]   rem;
  logic [COUNT_WIDTH:0]   rem_next;
  logic [COUNT_WIDTH:0]   trial;
  logic [COUNT_WIDTH-1:0] guard2;
  logic [CNT_W-1:0]       cnt;
  logic                   first;
  logic                   fits;

  assign guard2 = {{(COUNT_WIDTH - GUARD_WIDTH - 1){1'b0}}, guard, 1'b0};
  assign busy   = (cnt != '0);

  always_comb begin
    trial    = first ? rem : {rem[COUNT_WIDTH-1:0], 1'b0};
    fits     = (trial >= {1'b0, period});
    rem_next = fits ? (trial - {1'b0, period}) : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      first <= 1'b0;
    end else if (start) begin
      cnt   <= CNT_W'(LIMIT_WIDTH);
      first <= 1'b1;
    end else if (busy) begin
      cnt   <= cnt - 1'b1;
      first <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, period - guard2};
      limit <= '0;
    end else if (busy) begin
      rem   <= rem_next;
      limit <= {limit[LIMIT_WIDTH-2:0], fits};
    end
  end

endmodule

`default_nettype wire

### src/svmm_scale_div.sv
// pipelined restoring divider for the overmodulation scale, one quotient bit per stage
// depends on svmm_pkg
`default_nettype none

module svmm_scale_div (
  input  logic                          clk,
  input  svmm_pkg::stage_en_t           en,
  input  logic [svmm_pkg::SPAN_WIDTH:0]   in_rem,
  input  logic [svmm_pkg::SPAN_WIDTH-1:0] in_span,
  input  svmm_pkg::div_tag_t            in_tag,
  output logic [svmm_pkg::SCALE_BITS-1:0] out_q,
  output svmm_pkg::div_tag_t            out_tag
);
  import svmm_pkg::*;

  logic [SPAN_WIDTH:0]   rem_s  [SCALE_BITS];
  logic [SPAN_WIDTH-1:0] span_s [SCALE_BITS];
  logic [SCALE_BITS-1:0] q_s    [SCALE_BITS];
  div_tag_t              tag_s  [SCALE_BITS];

  for (genvar k = 0; k < SCALE_BITS; k++) begin : g_stage
    logic [SPAN_WIDTH:0]   src_rem;
    logic [SPAN_WIDTH-1:0] src_span;
    logic [SCALE_BITS-1:0] src_q;
    div_tag_t              src_tag;
    logic [SPAN_WIDTH:0]   trial;
    logic                  fits;

    if (k == 0) begin : g_first
      assign src_rem  = in_rem;
      assign src_span = in_span;
      assign src_q    = '0;
      assign src_tag  = in_tag;
    end else begin : g_next
      assign src_rem  = rem_s[k-1];
      assign src_span = span_s[k-1];
      assign src_q    = q_s[k-1];
      assign src_tag  = tag_s[k-1];
    end

    assign trial = {src_rem[SPAN_WIDTH-1:0], 1'b0};
    assign fits  = (trial >= {1'b0, src_span});

    always_ff @(posedge clk) begin
      if (en[S_DIV+k]) begin
        rem_s[k]  <= fits ? (trial - {1'b0, src_span}) : trial;
        span_s[k] <= src_span;
        q_s[k]    <= {src_q[SCALE_BITS-2:0], fits};
        tag_s[k]  <= src_tag;
      end
    end
  end

  assign out_q   = q_s[SCALE_BITS-1];
  assign out_tag = tag_s[SCALE_BITS-1];

endmodule

`default_nettype wire

### src/svmm_lane.sv
// one phase lane: scaling, duty word after injection, compare value and guard clamp
// depends on svmm_pkg
`default_nettype none

module svmm_lane (
  input  logic                            clk,
  input  svmm_pkg::stage_en_t             en,
  input  svmm_pkg::timing_t               tm,
  input  svmm_pkg::cmd_t                  ph,
  input  logic [svmm_pkg::SCALE_WIDTH-1:0]  scale,
  input  logic signed [svmm_pkg::SUM_WIDTH-1:0] sum,
  output svmm_pkg::cmd_t                  scaled,
  output logic [svmm_pkg::COUNT_WIDTH-1:0]  compare
);
  import svmm_pkg::*;

  localparam int PROD_W = CMD_WIDTH + SCALE_WIDTH + 1;
  localparam int WF_W   = CMD_WIDTH + 3;
  localparam int WP_W   = W_WIDTH + COUNT_WIDTH;
  localparam int HALF     = 2 ** (SCALE_BITS - 1);
  localparam int TWO_ONE  = 2 ** (FRAC_BITS + 1);
  localparam int FOUR_ONE = 2 ** (FRAC_BITS + 2);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;
  cmd_t                     scaled_m;
  logic signed [WF_W-1:0]   w_full;
  logic [W_WIDTH-1:0]       w_c;
  logic [W_WIDTH-1:0]       w_clamped;
  logic [WP_W-1:0]          wp;
  logic [WP_W:0]            wp_rnd;
  logic [COUNT_WIDTH-1:0]   c_raw;
  logic [COUNT_WIDTH-1:0]   lo;
  logic [COUNT_WIDTH-1:0]   hi;
  logic [COUNT_WIDTH-1:0]   c_next;

  assign rnd = prod + $signed(PROD_W'(HALF));

  assign w_full = $signed(WF_W'(TWO_ONE)) - ($signed(WF_W'(scaled_m)) <<< 1)
                + $signed(WF_W'(sum));

  always_comb begin
    if (w_full < $signed(WF_W'(0))) begin
      w_clamped = '0;
    end else if (w_full > $signed(WF_W'(FOUR_ONE))) begin
      w_clamped = W_WIDTH'(FOUR_ONE);
    end else begin
      w_clamped = w_full[W_WIDTH-1:0];
    end
  end

  assign wp_rnd = {1'b0, wp} + (WP_W + 1)'(TWO_ONE);
  assign c_raw  = wp_rnd[FRAC_BITS+2 +: COUNT_WIDTH];
  assign lo     = COUNT_WIDTH'(tm.guard);
  assign hi     = tm.period - lo;

  always_comb begin
    if (tm.bad) begin
      c_next = tm.period >> 1;
    end else if (c_raw < lo) begin
      c_next = lo;
    end else if (c_raw > hi) begin
      c_next = hi;
    end else begin
      c_next = c_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      prod <= ph * $signed({1'b0, scale});
    end
    if (en[S_RND]) begin
      scaled <= rnd[SCALE_BITS +: CMD_WIDTH];
    end
    if (en[S_MRG]) begin
      scaled_m <= scaled;
    end
    if (en[S_W]) begin
      w_c <= w_clamped;
    end
    if (en[S_PM]) begin
      wp <= w_c * tm.period;
    end
    if (en[S_OUT]) begin
      compare <= c_next;
    end
  end

endmodule

`default_nettype wire

### src/svmm_merge.sv
// merge of the three lanes: max plus min, sector, zero-sequence value and scale
// depends on svmm_pkg
`default_nettype none

module svmm_merge (
  input  logic                             clk,
  input  svmm_pkg::stage_en_t              en,
  input  svmm_pkg::timing_t                tm,
  input  svmm_pkg::cmd_t [2:0]             scaled,
  input  logic [svmm_pkg::SCALE_WIDTH-1:0]   scale_in,
  output logic signed [svmm_pkg::SUM_WIDTH-1:0] sum,
  output logic [svmm_pkg::SECTOR_WIDTH-1:0]  sector,
  output logic [svmm_pkg::SCALE_WIDTH-1:0]   scale_factor,
  output svmm_pkg::cmd_t                   zero_seq
);
  import svmm_pkg::*;

  localparam int ZMAX = 2 ** (CMD_WIDTH - 1) - 1;
  localparam int ZMIN = -(2 ** (CMD_WIDTH - 1));

  function automatic logic [SECTOR_WIDTH-1:0] sector_of(cmd_t a, cmd_t b, cmd_t c);
    logic [SECTOR_WIDTH-1:0] s;
    if (a >= b) begin
      if (b >= c) s = SECTOR_ABC;
      else if (a >= c) s = SECTOR_ACB;
      else s = SECTOR_CAB;
    end else begin
      if (a >= c) s = SECTOR_BAC;
      else if (b >= c) s = SECTOR_BCA;
      else s = SECTOR_CBA;
    end
    return s;
  endfunction

  logic [SCALE_WIDTH-1:0]  scale_r;
  logic [SCALE_WIDTH-1:0]  scale_m;
  logic [SCALE_WIDTH-1:0]  scale_w;
  logic [SCALE_WIDTH-1:0]  scale_p;
  logic [SCALE_WIDTH-1:0]  scale_o;
  logic [SECTOR_WIDTH-1:0] sector_m;
  logic [SECTOR_WIDTH-1:0] sector_w;
  logic [SECTOR_WIDTH-1:0] sector_p;
  cmd_t                    mx;
  cmd_t                    mn;
  logic signed [SUM_WIDTH:0]   nsum;
  logic signed [SUM_WIDTH-1:0] half;
  cmd_t                    zs_sat;
  cmd_t                    zs_w;
  cmd_t                    zs_p;

  assign mx = max3(scaled[0], scaled[1], scaled[2]);
  assign mn = min3(scaled[0], scaled[1], scaled[2]);

  assign nsum = -$signed((SUM_WIDTH + 1)'(sum));
  assign half = nsum[SUM_WIDTH:1];

  always_comb begin
    if (tm.bad) begin
      zs_sat = '0;
    end else if (half > $signed(SUM_WIDTH'(ZMAX))) begin
      zs_sat = CMD_WIDTH'(ZMAX);
    end else if (half < $signed(SUM_WIDTH'(ZMIN))) begin
      zs_sat = CMD_WIDTH'(ZMIN);
    end else begin
      zs_sat = half[CMD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      scale_r <= scale_in;
    end
    if (en[S_RND]) begin
      scale_m <= scale_r;
    end
    if (en[S_MRG]) begin
      sum      <= $signed(SUM_WIDTH'(mx)) + $signed(SUM_WIDTH'(mn));
      sector_m <= sector_of(scaled[0], scaled[1], scaled[2]);
      scale_w  <= scale_m;
    end
    if (en[S_W]) begin
      zs_w     <= zs_sat;
      sector_w <= sector_m;
      scale_p  <= scale_w;
    end
    if (en[S_PM]) begin
      zs_p     <= zs_w;
      sector_p <= sector_w;
      scale_o  <= scale_p;
    end
    if (en[S_OUT]) begin
      zero_seq     <= zs_p;
      sector       <= sector_p;
      scale_factor <= scale_o;
    end
  end

endmodule

`default_nettype wire
